// ===== rtl/core/per_cpu_page_free_list_assert.svh =====
// ----------------------------------------------------------------------------
// per_cpu_page_free_list assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_FREE_LIST_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PCPFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcpfl assertion failed");
// next-cycle implication
`define PCPFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcpfl assertion failed");
`else
`define PCPFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCPFL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pcpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpfl_pkg
// types and constants shared by the per-cpu page free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pcpfl_pkg;

	localparam int CPU_COUNT  = 8;
	localparam int CPU_W      = 3;
	localparam int MAX_PAGES  = 32768;
	localparam int IDX_W      = $clog2(MAX_PAGES);
	localparam int LINK_W     = IDX_W + 1;
	localparam int ADDR_W     = 34;
	localparam int STOP_W     = 35;
	localparam int PAGE_SHIFT = 12;
	localparam int PG_W       = ADDR_W - PAGE_SHIFT;
	localparam int CFG_W      = STOP_W;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FREED     = 2'd1,
		ST_NO_MEMORY = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_REGION_START = 1'b0,
		CFG_REGION_STOP  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [CPU_W-1:0]   cpu;
		logic [ADDR_W-1:0]  address;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  page_address;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic pop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic has_src;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcpfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcpfl_ctrl
// request sequencer: accepts requests, holds busy across a list pop
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_cpu_page_free_list_assert.svh"

module pcpfl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire pcpfl_pkg::sts_t  sts,
	output pcpfl_pkg::cmd_t       cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;
	logic   pop_needed;

	assign accept     = start && !busy;
	assign pop_needed = sts.is_alloc && sts.has_src;
	assign busy       = (state_q == S_POP);
	assign done       = done_q;
	assign cmd.accept = accept;
	assign cmd.pop    = (state_q == S_POP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && pop_needed) begin
						state_q <= S_POP;
						done_q  <= 1'b0;
					end else begin
						done_q  <= accept;
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	`PCPFL_ASSERT_IMP(a_busy_no_done, clk, arst_n, busy, !done_q)
	`PCPFL_ASSERT_NXT(a_pop_done, clk, arst_n, state_q == S_POP, done_q && !busy)
	`PCPFL_ASSERT_NXT(a_pop_enter, clk, arst_n, accept && pop_needed, busy && !done_q)

endmodule

`default_nettype wire

// ===== rtl/core/pcpfl_dp.sv =====
// ----------------------------------------------------------------------------
// pcpfl_dp
// region registers, list heads, link memory, address check and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_cpu_page_free_list_assert.svh"

module pcpfl_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pcpfl_pkg::req_t             request,
	input  wire pcpfl_pkg::cmd_t             cmd,
	output pcpfl_pkg::sts_t                  sts,
	input  wire logic                        wr_en,
	input  wire pcpfl_pkg::cfg_idx_t         wr_index,
	input  wire logic [pcpfl_pkg::CFG_W-1:0] wr_data,
	output pcpfl_pkg::rsp_t                  result
);

	logic [pcpfl_pkg::ADDR_W-1:0] start_q;
	logic [pcpfl_pkg::STOP_W-1:0] stop_q;

	logic [pcpfl_pkg::IDX_W-1:0]  head_q [pcpfl_pkg::CPU_COUNT];
	logic [pcpfl_pkg::CPU_COUNT-1:0] nonempty_q;

	logic [pcpfl_pkg::LINK_W-1:0] link_mem [pcpfl_pkg::MAX_PAGES];
	logic [pcpfl_pkg::LINK_W-1:0] link_q;
	logic [pcpfl_pkg::CPU_W-1:0]  src_q;
	pcpfl_pkg::rsp_t              rsp_q;

	logic [pcpfl_pkg::PG_W-1:0]   base;
	logic [pcpfl_pkg::PG_W-1:0]   diff;
	logic [pcpfl_pkg::IDX_W-1:0]  free_idx;
	logic                         free_ok;
	logic [pcpfl_pkg::LINK_W-1:0] free_link;
	logic                         do_free;
	logic [pcpfl_pkg::CPU_W-1:0]  low_sel;
	logic [pcpfl_pkg::CPU_W-1:0]  src;
	logic [pcpfl_pkg::IDX_W-1:0]  src_head;
	logic [pcpfl_pkg::PG_W-1:0]   page_pg;
	logic                         do_read;
	logic [pcpfl_pkg::LINK_W-1:0] link_dec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			stop_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pcpfl_pkg::CFG_REGION_START: start_q <= wr_data[pcpfl_pkg::ADDR_W-1:0];
				pcpfl_pkg::CFG_REGION_STOP:  stop_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// free address check
	assign base     = start_q[pcpfl_pkg::ADDR_W-1:pcpfl_pkg::PAGE_SHIFT];
	assign diff     = request.address[pcpfl_pkg::ADDR_W-1:pcpfl_pkg::PAGE_SHIFT] - base;
	assign free_idx = diff[pcpfl_pkg::IDX_W-1:0];
	assign free_ok  = (request.address[pcpfl_pkg::PAGE_SHIFT-1:0] == '0)
		&& (request.address >= start_q)
		&& ({1'b0, request.address} < stop_q)
		&& (diff[pcpfl_pkg::PG_W-1:pcpfl_pkg::IDX_W] == '0);
	assign free_link = nonempty_q[request.cpu]
		? ({1'b0, head_q[request.cpu]} + pcpfl_pkg::LINK_W'(1)) : '0;
	assign do_free  = cmd.accept && (request.kind == pcpfl_pkg::KIND_FREE) && free_ok;

	// lowest non-empty list
	always_comb begin
		low_sel = '0;
		for (int i = pcpfl_pkg::CPU_COUNT - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				low_sel = pcpfl_pkg::CPU_W'(i);
			end
		end
	end

	assign src      = nonempty_q[request.cpu] ? request.cpu : low_sel;
	assign src_head = head_q[src];
	assign page_pg  = base + pcpfl_pkg::PG_W'(src_head);

	assign sts.is_alloc = (request.kind == pcpfl_pkg::KIND_ALLOC);
	assign sts.has_src  = |nonempty_q;

	assign do_read  = cmd.accept && sts.is_alloc && sts.has_src;
	assign link_dec = link_q - pcpfl_pkg::LINK_W'(1);

	// link memory
	always_ff @(posedge clk) begin
		if (do_free) begin
			link_mem[free_idx] <= free_link;
		end
		if (do_read) begin
			link_q <= link_mem[src_head];
		end
	end

	// list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			for (int i = 0; i < pcpfl_pkg::CPU_COUNT; i++) begin
				head_q[i] <= '0;
			end
		end else if (cmd.pop) begin
			if (link_q == '0) begin
				nonempty_q[src_q] <= 1'b0;
				head_q[src_q]     <= '0;
			end else begin
				head_q[src_q]     <= link_dec[pcpfl_pkg::IDX_W-1:0];
			end
		end else if (do_free) begin
			nonempty_q[request.cpu] <= 1'b1;
			head_q[request.cpu]     <= free_idx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			src_q <= src;
			if (request.kind == pcpfl_pkg::KIND_FREE) begin
				rsp_q.status       <= free_ok ? pcpfl_pkg::ST_FREED : pcpfl_pkg::ST_BAD_FREE;
				rsp_q.page_address <= '0;
			end else if (sts.has_src) begin
				rsp_q.status       <= pcpfl_pkg::ST_ALLOCATED;
				rsp_q.page_address <= {page_pg, {pcpfl_pkg::PAGE_SHIFT{1'b0}}};
			end else begin
				rsp_q.status       <= pcpfl_pkg::ST_NO_MEMORY;
				rsp_q.page_address <= '0;
			end
		end
	end

	assign result = rsp_q;

	`PCPFL_ASSERT_IMP(a_pop_listed, clk, arst_n, cmd.pop, nonempty_q[src_q])
	`PCPFL_ASSERT_IMP(a_pop_no_accept, clk, arst_n, cmd.pop, !cmd.accept)

endmodule

`default_nettype wire

// ===== rtl/core/per_cpu_page_free_list.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_free_list
// page allocator with one lifo free list of 4 KiB pages per cpu
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Free requests and
// requests answered with out of memory or a bad free address return their
// result on the cycle after acceptance and keep busy low, so one such
// request can be taken every cycle. An allocation that pops a list enters
// the pop state, where busy is high, and returns its result as it leaves it:
// the next link of the popped page comes out of the registered read port
// of the link memory before the list head can move. Each result is shown
// for exactly one cycle with done high; the receiver cannot stall it.
// Lists are empty after reset and the link memory needs no clearing pass.
// The user must write region_start and region_stop via wr_en, wr_index and
// wr_data only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_free_list (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire pcpfl_pkg::req_t             request,
	output logic                             done,
	output pcpfl_pkg::rsp_t                  result,
	input  wire logic                        wr_en,
	input  wire pcpfl_pkg::cfg_idx_t         wr_index,
	input  wire logic [pcpfl_pkg::CFG_W-1:0] wr_data
);

	pcpfl_pkg::cmd_t cmd;
	pcpfl_pkg::sts_t sts;

	pcpfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pcpfl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.sts      (sts),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== bench/page_list_checker.sv =====
// ----------------------------------------------------------------------------
// page_list_checker
// watches the request, result and register ports of the per-cpu page free
// list allocator, keeps its own copy of the lists and the region registers,
// works out the result of every accepted request and compares each result
// that comes back, field by field, with the oldest one still owed
// ----------------------------------------------------------------------------
module page_list_checker import pcpfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  req_t              request,
	input  logic              done,
	input  rsp_t              result,
	input  logic              wr_en,
	input  cfg_idx_t          wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	output int                owed,
	output int                mismatches
);

	logic [ADDR_W-1:0]    region_start;
	logic [STOP_W-1:0]    region_stop;
	logic [IDX_W-1:0]     list_top [CPU_COUNT];
	logic [CPU_COUNT-1:0] list_filled;
	logic [LINK_W-1:0]    page_link [MAX_PAGES];
	rsp_t                 owed_responses [$];
	int                   errs;

	// takes the head page off list c and gives its index
	function automatic logic [IDX_W-1:0] take_head(input int c);
		logic [IDX_W-1:0]  idx;
		logic [LINK_W-1:0] lnk;
		idx = list_top[c];
		lnk = page_link[idx];
		if (lnk == '0 || lnk > MAX_PAGES) begin
			list_filled[c] = 1'b0;
			list_top[c] = '0;
		end else begin
			list_top[c] = IDX_W'(lnk - 1'b1);
		end
		return idx;
	endfunction

	// applies one request to the lists and gives the answer it earns
	function automatic rsp_t page_outcome(input req_t r);
		rsp_t              o;
		logic [PG_W-1:0]   base;
		logic [PG_W-1:0]   diff;
		logic [PG_W:0]     sum;
		logic [IDX_W-1:0]  idx;
		logic              ok;
		int                src;
		base = region_start[ADDR_W-1:PAGE_SHIFT];
		o.page_address = '0;
		if (r.kind == KIND_FREE) begin
			ok = r.address[PAGE_SHIFT-1:0] == '0 && r.address >= region_start &&
				{1'b0, r.address} < region_stop && r.cpu < CPU_COUNT;
			diff = r.address[ADDR_W-1:PAGE_SHIFT] - base;
			ok = ok && diff < MAX_PAGES;
			if (ok) begin
				idx = diff[IDX_W-1:0];
				page_link[idx] = list_filled[r.cpu] ? LINK_W'(list_top[r.cpu]) + 1'b1 : '0;
				list_top[r.cpu] = idx;
				list_filled[r.cpu] = 1'b1;
				o.status = ST_FREED;
			end else begin
				o.status = ST_BAD_FREE;
			end
		end else begin
			src = -1;
			if (r.cpu < CPU_COUNT && list_filled[r.cpu]) begin
				src = r.cpu;
			end else begin
				for (int i = CPU_COUNT - 1; i >= 0; i--) begin
					if (list_filled[i])
						src = i;
				end
			end
			if (src >= 0) begin
				idx = take_head(src);
				sum = base + idx;
				o.page_address = {sum[PG_W-1:0], {PAGE_SHIFT{1'b0}}};
				o.status = ST_ALLOCATED;
			end else begin
				o.status = ST_NO_MEMORY;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			region_start = '0;
			region_stop = '0;
			list_filled = '0;
			for (int i = 0; i < CPU_COUNT; i++)
				list_top[i] = '0;
			owed_responses.delete();
			errs = 0;
			owed <= 0;
			mismatches <= 0;
		end else begin
			if (done) begin
				if (owed_responses.size() == 0) begin
					errs++;
					$display("%0t: result with no request outstanding, got status %0d address %h",
						$time, result.status, result.page_address);
				end else begin
					want = owed_responses.pop_front();
					if (result.status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, result.status);
					end
					if (result.page_address !== want.page_address) begin
						errs++;
						$display("%0t: page_address expected %h got %h",
							$time, want.page_address, result.page_address);
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					CFG_REGION_START: region_start = wr_data[ADDR_W-1:0];
					CFG_REGION_STOP:  region_stop = wr_data[STOP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				owed_responses.push_back(page_outcome(request));
			owed <= owed_responses.size();
			mismatches <= errs;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the per-cpu page free list allocator: a directed run through empty
// lists, bad free addresses, lifo order, stealing, a double free and a region
// move, then random requests under several region settings, sent in bursts
// with random gaps; the checker beside the block scores every result
// ----------------------------------------------------------------------------
module tb_top;
	import pcpfl_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam longint unsigned PAGE = 4096;
	localparam longint unsigned TOP_STOP = 64'h4_0000_0000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	req_t             request = '0;
	logic             done;
	rsp_t             result;
	logic             wr_en = 1'b0;
	cfg_idx_t         wr_index = CFG_REGION_START;
	logic [CFG_W-1:0] wr_data = '0;
	int               owed;
	int               mismatches;
	int               idle_cycles = 0;
	int               burst_left = 0;
	longint unsigned  region_lo = 0;
	longint unsigned  region_hi = 0;

	always #10 clk = ~clk;

	per_cpu_page_free_list u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	page_list_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.owed       (owed),
		.mismatches (mismatches)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[per_cpu_page_free_list] ERROR");
			$finish;
		end
	end

	// holds the request until taken; start stays high for a following request
	task automatic send(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_region(input longint unsigned lo, input longint unsigned hi);
		drain();
		wr_en <= 1'b1;
		wr_index <= CFG_REGION_START;
		wr_data <= CFG_W'(lo);
		@(posedge clk);
		wr_index <= CFG_REGION_STOP;
		wr_data <= CFG_W'(hi);
		@(posedge clk);
		wr_en <= 1'b0;
		region_lo = lo;
		region_hi = hi;
	endtask

	function automatic req_t make(input kind_t k, input int c, input longint unsigned a);
		req_t r;
		r.kind = k;
		r.cpu = CPU_W'(c);
		r.address = ADDR_W'(a);
		return r;
	endfunction

	// mostly frees of pages inside the region and allocations, some junk frees
	function automatic req_t random_request();
		req_t            r;
		longint unsigned lo_pg;
		longint unsigned hi_pg;
		longint unsigned span;
		longint unsigned pg;
		int              pick;
		r.cpu = CPU_W'($urandom_range(0, CPU_COUNT - 1));
		r.address = ADDR_W'({$urandom, $urandom});
		if ($urandom_range(0, 99) < 45) begin
			r.kind = KIND_ALLOC;
			return r;
		end
		r.kind = KIND_FREE;
		lo_pg = (region_lo + PAGE - 1) >> PAGE_SHIFT;
		hi_pg = (region_hi + PAGE - 1) >> PAGE_SHIFT;
		if (hi_pg > (region_lo >> PAGE_SHIFT) + MAX_PAGES)
			hi_pg = (region_lo >> PAGE_SHIFT) + MAX_PAGES;
		pick = $urandom_range(0, 9);
		if (lo_pg < hi_pg && pick < 8) begin
			span = hi_pg - lo_pg;
			if (pick == 7)
				pg = hi_pg - 1 - ($urandom_range(0, 3) % span);
			else
				pg = lo_pg + ($urandom_range(0, 47) % span);
			r.address = ADDR_W'(pg << PAGE_SHIFT);
		end else begin
			case ($urandom_range(0, 3))
				0: ;
				// first page past the stop or the index limit
				1: r.address = ADDR_W'(hi_pg << PAGE_SHIFT);
				// page just below the region
				2: r.address = ADDR_W'(((region_lo >> PAGE_SHIFT) - 1) << PAGE_SHIFT);
				default: r.address = ADDR_W'((lo_pg << PAGE_SHIFT) | $urandom_range(1, 4095));
			endcase
		end
		return r;
	endfunction

	initial begin
		longint unsigned lo;
		longint unsigned hi;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: empty lists and an empty region
		send(make(KIND_ALLOC, 0, 0));
		send(make(KIND_FREE, 0, 0));

		set_region(64'h1_0000_0000, 64'h1_0000_4000);
		send(make(KIND_FREE, 0, 64'h1_0000_0004));
		send(make(KIND_FREE, 0, 64'h0_FFFF_F000));
		send(make(KIND_FREE, 0, 64'h1_0000_4000));
		send(make(KIND_FREE, 0, 64'h1_0000_0000));
		send(make(KIND_FREE, 0, 64'h1_0000_1000));
		send(make(KIND_FREE, 3, 64'h1_0000_3000));
		send(make(KIND_ALLOC, 0, 64'h3_FFFF_FFFF));
		send(make(KIND_ALLOC, 5, 0));
		send(make(KIND_ALLOC, 7, 0));
		send(make(KIND_ALLOC, 2, 0));
		// double free makes a self loop, a free on another cpu breaks it
		send(make(KIND_FREE, 1, 64'h1_0000_2000));
		send(make(KIND_FREE, 1, 64'h1_0000_2000));
		send(make(KIND_ALLOC, 1, 0));
		send(make(KIND_FREE, 2, 64'h1_0000_2000));
		send(make(KIND_ALLOC, 1, 0));
		send(make(KIND_ALLOC, 2, 0));
		send(make(KIND_ALLOC, 1, 0));
		// listed page reported against a moved region
		send(make(KIND_FREE, 4, 64'h1_0000_2000));
		set_region(64'h3_FFFF_F000, TOP_STOP);
		send(make(KIND_ALLOC, 4, 0));

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					lo = 0;
					hi = TOP_STOP;
				end
				1: begin
					lo = 64'h3_FFFF_FFFF;
					hi = TOP_STOP;
				end
				2: begin
					lo = 64'h3_FFFF_F000;
					hi = TOP_STOP;
				end
				3: begin
					lo = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
					if ($urandom_range(0, 1) == 1)
						lo = lo & ~(PAGE - 1);
					hi = lo + $urandom_range(1, 40) * PAGE + $urandom_range(0, 4095);
				end
				4: begin
					lo = longint'($urandom_range(0, (1 << PG_W) - MAX_PAGES - 16)) << PAGE_SHIFT;
					hi = lo + (MAX_PAGES + 5) * PAGE;
				end
				5: begin
					lo = 0;
					hi = 0;
				end
				default: begin
					lo = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
					hi = {$urandom, $urandom} % (TOP_STOP + 1);
				end
			endcase
			if (hi > TOP_STOP)
				hi = TOP_STOP;
			set_region(lo, hi);
			repeat (190) send(random_request());
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("[per_cpu_page_free_list] OK");
		else
			$display("[per_cpu_page_free_list] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pcpfl_pkg.sv
rtl/core/pcpfl_ctrl.sv
rtl/core/pcpfl_dp.sv
rtl/core/per_cpu_page_free_list.sv
bench/page_list_checker.sv
bench/tb_top.sv
